// ----- design/trithemius_quadratic_key_cipher_macros.svh -----
// Assertion helpers for the checker file.
`ifndef TRITHEMIUS_QUADRATIC_KEY_CIPHER_MACROS_SVH
`define TRITHEMIUS_QUADRATIC_KEY_CIPHER_MACROS_SVH

// Condition on this edge implies consequence on the same edge, outside reset.
`define TQKC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition on this edge implies consequence on the next edge, outside reset.
`define TQKC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-edge check that also runs while reset is applied.
`define TQKC_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tqkc_pkg.sv -----
`timescale 1ns / 1ps

package tqkc_pkg;

    localparam int ALPHA_SIZE  = 36;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_W       = 6;

    // x / 36 == (x * 1821) >> 16 for every x below 3311
    localparam int          DIV_SHIFT = 16;
    localparam logic [10:0] DIV_RECIP = 11'd1821;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_SQUARE = 2'd1;
    localparam logic [1:0] CFG_LINEAR = 2'd2;
    localparam logic [1:0] CFG_CONST  = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       invalid;
    } t_out;

    typedef struct packed {
        logic             mode;
        logic [CFG_W-1:0] coef_square;
        logic [CFG_W-1:0] coef_linear;
        logic [CFG_W-1:0] coef_const;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{mode: 1'b0, coef_square: 6'd2, coef_linear: 6'd5,
                                   coef_const: 6'd3};

    // one queued word: raw byte, its alphabet index and the two key products
    typedef struct packed {
        logic [7:0]  raw;
        logic        invalid;
        logic [5:0]  idx;
        logic [10:0] prod_sq;
        logic [10:0] prod_lin;
    } t_job;

    typedef struct packed {
        logic       hit;
        logic [5:0] idx;
    } t_lookup;

    // n^2 mod 36
    localparam logic [5:0] SQ_MOD [ALPHA_SIZE] = '{
        6'd0,  6'd1,  6'd4,  6'd9,  6'd16, 6'd25, 6'd0,  6'd13, 6'd28,
        6'd9,  6'd28, 6'd13, 6'd0,  6'd25, 6'd16, 6'd9,  6'd4,  6'd1,
        6'd0,  6'd1,  6'd4,  6'd9,  6'd16, 6'd25, 6'd0,  6'd13, 6'd28,
        6'd9,  6'd28, 6'd13, 6'd0,  6'd25, 6'd16, 6'd9,  6'd4,  6'd1
    };

    function automatic logic [5:0] mod_once(input logic [5:0] v);
        logic [5:0] r;
        r = (v >= 6'(ALPHA_SIZE)) ? v - 6'(ALPHA_SIZE) : v;
        return r;
    endfunction

    function automatic t_lookup byte_to_idx(input logic [7:0] b);
        t_lookup    r;
        logic [7:0] d;
        d = b - 8'hE0;
        r = '{hit: 1'b0, idx: 6'd0};
        if (b >= 8'hE0 && b <= 8'hE5) begin
            r = '{hit: 1'b1, idx: d[5:0]};
        end else if (b == 8'hB8) begin
            r = '{hit: 1'b1, idx: 6'd6};
        end else if (b >= 8'hE6) begin
            r = '{hit: 1'b1, idx: d[5:0] + 6'd1};
        end else if (b == 8'h20) begin
            r = '{hit: 1'b1, idx: 6'd33};
        end else if (b == 8'h2C) begin
            r = '{hit: 1'b1, idx: 6'd34};
        end else if (b == 8'h2E) begin
            r = '{hit: 1'b1, idx: 6'd35};
        end
        return r;
    endfunction

    function automatic logic [7:0] idx_to_byte(input logic [5:0] i);
        logic [7:0] r;
        if (i < 6'd6) begin
            r = 8'hE0 + 8'(i);
        end else if (i == 6'd6) begin
            r = 8'hB8;
        end else if (i <= 6'd32) begin
            r = 8'hDF + 8'(i);
        end else if (i == 6'd33) begin
            r = 8'h20;
        end else if (i == 6'd34) begin
            r = 8'h2C;
        end else begin
            r = 8'h2E;
        end
        return r;
    endfunction

endpackage

// ----- design/trithemius_quadratic_key_cipher.sv -----
`timescale 1ns / 1ps

// Channel   Valid        Stall        Word
// ------    ----------   ----------   ---------------------------
// input     i_in_valid   o_in_stall   i_in_data  (in_byte, first)
// output    o_out_valid  i_out_stall  o_out_data (out_byte, invalid)
// config    i_cfg_we     -            i_cfg_idx, i_cfg_data
//
// The front takes one word per cycle until the queue holds QUEUE_DEPTH words.
// The back steps each word through pop, sum, divide by 36, key and map, and pops
// the next word only after the map step, which an output stall holds.
// Reset is synchronous and clears the position, queue, sequencer, key registers and output valid.
// A stall on the output holds the result; the queue keeps taking input meanwhile until full.

module trithemius_quadratic_key_cipher #(
    parameter int QUEUE_DEPTH = tqkc_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tqkc_pkg::t_in              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tqkc_pkg::t_out             o_out_data,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [tqkc_pkg::CFG_W-1:0] i_cfg_data
);

    tqkc_pkg::t_cfg r_cfg;
    tqkc_pkg::t_job w_push_job;
    tqkc_pkg::t_job w_pop_job;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tqkc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tqkc_pkg::CFG_MODE:   r_cfg.mode        <= i_cfg_data[0];
                tqkc_pkg::CFG_SQUARE: r_cfg.coef_square <= i_cfg_data;
                tqkc_pkg::CFG_LINEAR: r_cfg.coef_linear <= i_cfg_data;
                tqkc_pkg::CFG_CONST:  r_cfg.coef_const  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tqkc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .i_cfg   (r_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    tqkc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    tqkc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .i_job   (w_pop_job),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

// ----- design/tqkc_front.sv -----
`timescale 1ns / 1ps

module tqkc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  tqkc_pkg::t_in  i_data,
    input  tqkc_pkg::t_cfg i_cfg,
    input  logic           i_full,
    output logic           o_push,
    output tqkc_pkg::t_job o_job
);

    logic [5:0]        r_pos;
    logic [5:0]        w_n;
    logic [5:0]        w_coef_sq;
    logic [5:0]        w_coef_lin;
    logic [11:0]       w_prod_sq;
    logic [11:0]       w_prod_lin;
    tqkc_pkg::t_lookup w_look;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    assign w_n        = i_data.first ? 6'd0 : r_pos;
    assign w_look     = tqkc_pkg::byte_to_idx(i_data.in_byte);
    assign w_coef_sq  = tqkc_pkg::mod_once(i_cfg.coef_square);
    assign w_coef_lin = tqkc_pkg::mod_once(i_cfg.coef_linear);
    // both products stay below 36*36
    assign w_prod_sq  = 12'(w_coef_sq) * 12'(tqkc_pkg::SQ_MOD[w_n]);
    assign w_prod_lin = 12'(w_coef_lin) * 12'(w_n);

    always_comb begin
        o_job.raw      = i_data.in_byte;
        o_job.invalid  = !w_look.hit;
        o_job.idx      = w_look.idx;
        o_job.prod_sq  = w_prod_sq[10:0];
        o_job.prod_lin = w_prod_lin[10:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 6'd0;
        end else if (o_push) begin
            r_pos <= (w_n == 6'(tqkc_pkg::ALPHA_SIZE - 1)) ? 6'd0 : w_n + 6'd1;
        end
    end

endmodule

// ----- design/tqkc_queue.sv -----
`timescale 1ns / 1ps

module tqkc_queue #(
    parameter int DEPTH = tqkc_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tqkc_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output tqkc_pkg::t_job o_job,
    output logic           o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tqkc_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] step(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= step(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= step(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- design/tqkc_back.sv -----
`timescale 1ns / 1ps

module tqkc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tqkc_pkg::t_cfg i_cfg,
    input  logic           i_empty,
    output logic           o_pop,
    input  tqkc_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_stall,
    output tqkc_pkg::t_out o_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_KEY  = 3'd3;
    localparam logic [2:0] ST_MAP  = 3'd4;

    logic [2:0]     r_state;
    logic [2:0]     n_state;
    tqkc_pkg::t_job r_job;
    logic [11:0]    r_sum;
    logic [6:0]     r_quo;
    logic [5:0]     r_key;
    tqkc_pkg::t_out r_out;
    logic           r_out_valid;

    logic [22:0]    w_prod;
    logic [11:0]    w_q36;
    logic [11:0]    w_rem;
    logic [6:0]     w_t;
    logic [6:0]     w_r;
    logic           w_load;

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign w_load  = (r_state == ST_MAP) && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign w_prod = 23'(r_sum) * 23'(tqkc_pkg::DIV_RECIP);
    assign w_q36  = {r_quo, 5'd0} + {3'd0, r_quo, 2'd0};
    assign w_rem  = r_sum - w_q36;

    always_comb begin
        if (i_cfg.mode) begin
            w_t = 7'(r_job.idx) + 7'(tqkc_pkg::ALPHA_SIZE) - 7'(r_key);
        end else begin
            w_t = 7'(r_job.idx) + 7'(r_key);
        end
        w_r = (w_t >= 7'(tqkc_pkg::ALPHA_SIZE)) ? w_t - 7'(tqkc_pkg::ALPHA_SIZE) : w_t;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM:  n_state = ST_DIV;
            ST_DIV:  n_state = ST_KEY;
            ST_KEY:  n_state = ST_MAP;
            ST_MAP: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == ST_SUM) begin
            r_sum <= 12'(r_job.prod_sq) + 12'(r_job.prod_lin)
                   + 12'(tqkc_pkg::mod_once(i_cfg.coef_const));
        end
        if (r_state == ST_DIV) begin
            r_quo <= w_prod[tqkc_pkg::DIV_SHIFT +: 7];
        end
        if (r_state == ST_KEY) begin
            r_key <= w_rem[5:0];
        end
        if (w_load) begin
            r_out.invalid  <= r_job.invalid;
            r_out.out_byte <= r_job.invalid ? r_job.raw : tqkc_pkg::idx_to_byte(w_r[5:0]);
        end
    end

endmodule

// ----- design/tqkc_checker.sv -----
`timescale 1ns / 1ps

`include "trithemius_quadratic_key_cipher_macros.svh"

module tqkc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input tqkc_pkg::t_out o_out_data
);

    logic w_held;
    logic w_ciphered;
    logic w_in_alpha;

    assign w_held     = o_out_valid && i_out_stall;
    assign w_ciphered = o_out_valid && !o_out_data.invalid;
    assign w_in_alpha = (o_out_data.out_byte >= 8'hE0) || (o_out_data.out_byte == 8'hB8)
                     || (o_out_data.out_byte == 8'h20) || (o_out_data.out_byte == 8'h2C)
                     || (o_out_data.out_byte == 8'h2E);

    // a held result keeps its word
    `TQKC_ASSERT_NEXT(a_out_hold, w_held, o_out_valid && $stable(o_out_data), "stalled word changed")

    // nothing comes out right after reset
    `TQKC_ASSERT_NEXT_RST(a_rst_quiet, !i_rst_n, !o_out_valid, "output valid right after reset")

    // a valid result not flagged invalid is always a byte of the alphabet
    `TQKC_ASSERT_NOW(a_alpha, w_ciphered, w_in_alpha, "enciphered byte outside the alphabet")

endmodule

bind trithemius_quadratic_key_cipher tqkc_checker u_tqkc_checker (.*);

// ----- sim/tb_trithemius_quadratic_key_cipher.sv -----
`timescale 1ns / 1ps

module tb_trithemius_quadratic_key_cipher;

    localparam int HOLD_CYCLES = 60;
    localparam int PHASES      = 9;
    localparam int PHASE_WORDS = 145;
    localparam int DIR_ROWS_N  = 24;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first;
        logic       typed;
        logic [7:0] exp_byte;
        logic       exp_inv;
    } t_dir_row;

    // typed expectations hold for the reset key (a=2, b=5, c=3, encrypt)
    localparam t_dir_row DIR_ROWS [DIR_ROWS_N] = '{
        '{8'hE0, 1'b1, 1'b1, 8'hE3, 1'b0},
        '{8'h00, 1'b0, 1'b1, 8'h00, 1'b1},
        '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hB8, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h20, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h2C, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h2E, 1'b1, 1'b1, 8'hE2, 1'b0},
        '{8'hE5, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hE6, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hDF, 1'b0, 1'b1, 8'hDF, 1'b1},
        '{8'hB7, 1'b0, 1'b1, 8'hB7, 1'b1},
        '{8'hB9, 1'b0, 1'b1, 8'hB9, 1'b1},
        '{8'h2D, 1'b0, 1'b1, 8'h2D, 1'b1},
        '{8'h1F, 1'b0, 1'b1, 8'h1F, 1'b1},
        '{8'h21, 1'b0, 1'b1, 8'h21, 1'b1},
        '{8'h7F, 1'b1, 1'b1, 8'h7F, 1'b1},
        '{8'h80, 1'b0, 1'b1, 8'h80, 1'b1},
        '{8'hFF, 1'b1, 1'b1, 8'h2E, 1'b0},
        '{8'hE0, 1'b0, 1'b1, 8'hE9, 1'b0},
        '{8'h2E, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hB8, 1'b1, 1'b1, 8'hE8, 1'b0},
        '{8'h2B, 1'b0, 1'b1, 8'h2B, 1'b1},
        '{8'h2F, 1'b0, 1'b1, 8'h2F, 1'b1},
        '{8'hE1, 1'b0, 1'b0, 8'h00, 1'b0}
    };

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    tqkc_pkg::t_in  in_data   = '0;
    logic           out_stall = 1'b0;
    logic           cfg_we    = 1'b0;
    logic [1:0]     cfg_idx   = tqkc_pkg::CFG_MODE;
    logic [5:0]     cfg_data  = '0;
    logic           in_stall;
    logic           out_valid;
    tqkc_pkg::t_out out_data;

    // predictor copy of the key registers and position
    logic       key_mode = 1'b0;
    logic [5:0] key_a    = 6'd2;
    logic [5:0] key_b    = 6'd5;
    logic [5:0] key_c    = 6'd3;
    int         char_pos = 0;

    tqkc_pkg::t_out pending_cipher [$];
    int   err_count    = 0;
    int   msg_left     = 0;
    bit   tx_noise     = 1'b1;
    bit   rx_noise     = 1'b1;
    bit   hold_pending = 1'b0;

    trithemius_quadratic_key_cipher dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    // -1 when the byte is outside the alphabet
    function automatic int letter_of(input logic [7:0] b);
        if (b >= 8'hE0 && b <= 8'hE5) return int'(b) - 'hE0;
        if (b == 8'hB8) return 6;
        if (b >= 8'hE6) return int'(b) - 'hDF;
        if (b == 8'h20) return 33;
        if (b == 8'h2C) return 34;
        if (b == 8'h2E) return 35;
        return -1;
    endfunction

    function automatic logic [7:0] byte_of(input int i);
        if (i < 6) return 8'(8'hE0 + i);
        if (i == 6) return 8'hB8;
        if (i <= 32) return 8'(8'hDF + i);
        if (i == 33) return 8'h20;
        if (i == 34) return 8'h2C;
        return 8'h2E;
    endfunction

    function automatic tqkc_pkg::t_out cipher_word(input tqkc_pkg::t_in w);
        tqkc_pkg::t_out r;
        int   m;
        int   k;
        if (w.first) char_pos = 0;
        m = letter_of(w.in_byte);
        if (m < 0) begin
            r.out_byte = w.in_byte;
            r.invalid  = 1'b1;
        end else begin
            k = (int'(key_a) * char_pos * char_pos + int'(key_b) * char_pos + int'(key_c))
                % tqkc_pkg::ALPHA_SIZE;
            r.out_byte = key_mode
                ? byte_of((m + tqkc_pkg::ALPHA_SIZE - k) % tqkc_pkg::ALPHA_SIZE)
                : byte_of((m + k) % tqkc_pkg::ALPHA_SIZE);
            r.invalid  = 1'b0;
        end
        char_pos = (char_pos + 1) % tqkc_pkg::ALPHA_SIZE;
        return r;
    endfunction

    // messages of random length; some stray restarts and out-of-alphabet bytes
    function automatic tqkc_pkg::t_in next_char();
        tqkc_pkg::t_in w;
        w.first = 1'b0;
        if (msg_left == 0) begin
            msg_left = $urandom_range(80, 1);
            w.first  = 1'b1;
        end else if ($urandom_range(99) < 3) begin
            w.first = 1'b1;
        end
        msg_left--;
        if ($urandom_range(99) < 78) begin
            w.in_byte = byte_of($urandom_range(tqkc_pkg::ALPHA_SIZE - 1));
        end else begin
            w.in_byte = 8'($urandom_range(255));
        end
        return w;
    endfunction

    task automatic flag_error(input string what, input int got, input int want);
        err_count++;
        $display("ERROR %0t: %s got %02h want %02h", $time, what, got, want);
    endtask

    task automatic feed_word(input tqkc_pkg::t_in w, input bit fixed,
                             input tqkc_pkg::t_out fixed_exp);
        tqkc_pkg::t_out pred;
        while (tx_noise && $urandom_range(99) < 16) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pred = cipher_word(w);
        pending_cipher.push_back(fixed ? fixed_exp : pred);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_cipher.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            tqkc_pkg::CFG_MODE:   key_mode = data[0];
            tqkc_pkg::CFG_SQUARE: key_a    = data;
            tqkc_pkg::CFG_LINEAR: key_b    = data;
            tqkc_pkg::CFG_CONST:  key_c    = data;
            default: ;
        endcase
    endtask

    task automatic set_key(input logic [5:0] m, input logic [5:0] a, input logic [5:0] b,
                           input logic [5:0] c);
        write_reg(tqkc_pkg::CFG_MODE, m);
        write_reg(tqkc_pkg::CFG_SQUARE, a);
        write_reg(tqkc_pkg::CFG_LINEAR, b);
        write_reg(tqkc_pkg::CFG_CONST, c);
        cfg_we <= 1'b0;
    endtask

    // receiver stall: random noise plus the occasional long hold
    initial begin
        forever begin
            @(posedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                out_stall <= 1'b1;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
            end
            out_stall <= rx_noise && ($urandom_range(99) < 16);
        end
    end

    always @(posedge clk) begin
        tqkc_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_cipher.size() == 0) begin
                flag_error("unexpected word", out_data.out_byte, 0);
            end else begin
                want = pending_cipher.pop_front();
                if (out_data.out_byte !== want.out_byte)
                    flag_error("out_byte", out_data.out_byte, want.out_byte);
                if (out_data.invalid !== want.invalid)
                    flag_error("invalid", out_data.invalid, want.invalid);
            end
        end
    end

    initial begin
        t_dir_row       row;
        tqkc_pkg::t_in  w;
        tqkc_pkg::t_out fx;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows: encrypt with the reset key, then again decrypting
        for (int walk = 0; walk < 2; walk++) begin
            if (walk == 1) begin
                drain_results();
                set_key(6'd1, key_a, key_b, key_c);
            end
            for (int r = 0; r < DIR_ROWS_N; r++) begin
                row         = DIR_ROWS[r];
                w.in_byte   = row.in_byte;
                w.first     = row.first;
                fx.out_byte = row.exp_byte;
                fx.invalid  = row.exp_inv;
                feed_word(w, row.typed && (walk == 0 || row.exp_inv), fx);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                0: set_key(6'd0, 6'd0, 6'd0, 6'd0);
                1: set_key(6'h3F, 6'd35, 6'd35, 6'd35);
                2: set_key(6'h3E, 6'd63, 6'd63, 6'd63);
                3: set_key(6'd1, 6'd36, 6'd0, 6'd63);
                default: set_key(6'($urandom_range(63)), 6'($urandom_range(63)),
                                 6'($urandom_range(63)), 6'($urandom_range(63)));
            endcase
            tx_noise = (ph != 4);
            rx_noise = (ph != 4);
            if (ph == 1 || ph == 5) hold_pending = 1'b1;
            fx = '0;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                feed_word(next_char(), 1'b0, fx);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (err_count == 0 && pending_cipher.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
